/* hw/rtl/spq_pkg.sv */
// Shared types and codes of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int TAG_W   = 32;
    localparam int PRIO_W  = 8;
    localparam int SEQ_W   = 8;
    localparam int ENTRY_W = TAG_W + PRIO_W + SEQ_W;

    // First member sits in the top bits: tag lands in the lowest bits.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

/* hw/rtl/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/spq_key_cmp.sv */
// Key comparator: flags a stored entry that is served after the new key.
`timescale 1ns / 1ps

module spq_key_cmp (
    input  spq_pkg::entry_t             stored,
    input  logic [spq_pkg::PRIO_W-1:0]  key_prio,
    input  logic [spq_pkg::SEQ_W-1:0]   key_seq,
    output logic                        ranks_after
);

    import spq_pkg::*;

    // Priority first, sequence tag breaks ties; equal keys do not rank after.
    assign ranks_after = {stored.prio, stored.seq} > {key_prio, key_seq};

endmodule

/* hw/rtl/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue: request sequencer, store and result register.
`timescale 1ns / 1ps

// Bounded priority queue of up to QUEUE_DEPTH job entries, kept as a sorted
// circular array in one RAM. Each request on the s_ channel is an insert
// (s_tuser = 0) or a remove of the head entry (s_tuser = 1) and yields
// exactly one result on the m_ channel. Entries come out in ascending
// priority number, then ascending sequence tag; an entry whose key equals
// stored ones goes after them. One request is worked at a time, and s_tready
// stays low until its result has been placed in the output register, which
// then waits on m_tready while the next request is taken. An insert walks
// back from the tail through a single comparator, one stored entry per
// cycle, moving each entry that ranks after the new key one slot on; the
// entries it compares, at most QUEUE_DEPTH - 1, all pass through the one
// RAM read port. No clearing pass is needed after reset: only live slots
// are ever read.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spq_pkg::ENTRY_W-1:0]  s_tdata,  // job_tag, priority_req, sequence_tag
    input  logic                         s_tuser,  // opcode
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spq_pkg::ENTRY_W-1:0]  m_tdata,  // out_job_tag, out_priority, out_sequence_tag
    output logic [1:0]                   m_tuser   // status
);

    import spq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] k_reg;        // logical position under compare, then insert slot
    entry_t           key_reg;
    status_t          res_status_reg;
    entry_t           res_entry_reg;
    logic             m_tvalid_reg;
    status_t          m_status_reg;
    entry_t           m_entry_reg;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             out_free;
    logic             ranks_after;
    entry_t           in_entry;
    logic [PTR_W-1:0] tail_pos;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    entry_t           rd_data;

    // Physical slot of a logical position counted from the head.
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_entry = entry_t'(s_tdata);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign tail_pos = PTR_W'(count_reg - CNT_W'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_entry_reg;
    assign m_tuser  = m_status_reg;

    // The single compare unit, fed from the RAM read data.
    spq_key_cmp u_cmp (
        .stored      (rd_data),
        .key_prio    (key_reg.prio),
        .key_seq     (key_reg.seq),
        .ranks_after (ranks_after)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read port: fetch the head for a remove, the tail to open an insert,
    // then the next entry down while the scan keeps shifting.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_REMOVE) begin
                        rd_en   = !is_empty;
                        rd_addr = head_reg;
                    end else begin
                        rd_en   = !is_full && !is_empty;
                        rd_addr = slot_of(head_reg, tail_pos);
                    end
                end
            end
            ST_SCAN: begin
                rd_en   = ranks_after && (k_reg != '0);
                rd_addr = slot_of(head_reg, PTR_W'(k_reg - PTR_W'(1)));
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Write port: move a later-ranked entry back one slot, or drop the new
    // entry into the gap.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, k_reg);
        wr_data = key_reg;
        case (state_reg)
            ST_SCAN: begin
                wr_en   = ranks_after;
                wr_addr = slot_of(head_reg, PTR_W'(k_reg + PTR_W'(1)));
                wr_data = rd_data;
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = slot_of(head_reg, k_reg);
                wr_data = key_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg        <= in_entry;
                        res_status_reg <= STATUS_OK;
                        res_entry_reg  <= '0;
                        if (s_tuser == OP_INSERT) begin
                            if (is_full) begin
                                res_status_reg <= STATUS_FULL;
                                state_reg      <= ST_EMIT;
                            end else if (is_empty) begin
                                k_reg     <= '0;
                                state_reg <= ST_PLACE;
                            end else begin
                                k_reg     <= tail_pos;
                                state_reg <= ST_SCAN;
                            end
                        end else begin
                            if (is_empty) begin
                                res_status_reg <= STATUS_EMPTY;
                                state_reg      <= ST_EMIT;
                            end else begin
                                state_reg <= ST_HEAD;
                            end
                        end
                    end
                end
                ST_HEAD: begin
                    // Head data is back from the RAM: take it and advance.
                    res_entry_reg <= rd_data;
                    head_reg      <= slot_of(head_reg, PTR_W'(1));
                    count_reg     <= count_reg - CNT_W'(1);
                    state_reg     <= ST_EMIT;
                end
                ST_SCAN: begin
                    if (ranks_after) begin
                        if (k_reg == '0) begin
                            state_reg <= ST_PLACE;
                        end else begin
                            k_reg <= k_reg - PTR_W'(1);
                        end
                    end else begin
                        k_reg     <= k_reg + PTR_W'(1);
                        state_reg <= ST_PLACE;
                    end
                end
                ST_PLACE: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Result register: load when the finished result can go out,
            // drop it once taken.
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_status_reg <= res_status_reg;
                m_entry_reg  <= res_entry_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checker of the sorted priority queue and its bind.
`timescale 1ns / 1ps

module spq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [spq_pkg::ENTRY_W-1:0]  m_tdata,
    input logic [1:0]                   m_tuser
);

    import spq_pkg::*;

    // One request at a time: a taken request closes the input.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // A result cannot appear the cycle straight after a request is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared without sequencing");

    // Refusals and empty removes carry no entry.
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == '0))
        else $error("error result carries entry data");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/sorted_priority_queue_check.sv */
// Checker of the sorted priority queue: predicts each result and compares it on the m_ channel.
`timescale 1ns / 1ps

module sorted_priority_queue_check #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [spq_pkg::ENTRY_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [spq_pkg::ENTRY_W-1:0] m_tdata,
    input  logic [1:0]                  m_tuser,
    output int                          mismatches,
    output int                          outstanding
);

    import spq_pkg::*;

    typedef struct packed {
        status_t status;
        entry_t  job;
    } queue_reply_t;

    // Predicted queue contents, head first, kept in service order.
    entry_t       queued_jobs[$];
    // Replies owed by the block, oldest first.
    queue_reply_t owed_replies[$];

    // Apply one request to the predicted queue and return the reply it earns.
    function automatic queue_reply_t serve_request(input logic op, input entry_t req);
        queue_reply_t reply;
        int           slot;
        reply.status = STATUS_OK;
        reply.job    = '0;
        if (op == OP_INSERT) begin
            if (queued_jobs.size() >= QUEUE_DEPTH) begin
                reply.status = STATUS_FULL;
            end else begin
                slot = queued_jobs.size();
                // Place after every entry that is served no later than the new key.
                for (int k = 0; k < queued_jobs.size(); k++) begin
                    if (queued_jobs[k].prio > req.prio ||
                        (queued_jobs[k].prio == req.prio && queued_jobs[k].seq > req.seq)) begin
                        slot = k;
                        break;
                    end
                end
                queued_jobs.insert(slot, req);
            end
        end else if (queued_jobs.size() == 0) begin
            reply.status = STATUS_EMPTY;
        end else begin
            reply.job = queued_jobs.pop_front();
        end
        return reply;
    endfunction

    always @(posedge aclk) begin
        queue_reply_t owed;
        entry_t       seen;
        if (!aresetn) begin
            queued_jobs.delete();
            owed_replies.delete();
        end else begin
            // A reply taken at this edge always belongs to an earlier request.
            if (m_tvalid && m_tready) begin
                seen = entry_t'(m_tdata);
                if (owed_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status %0d job %h prio %0d seq %0d",
                                 $realtime, m_tuser, seen.tag, seen.prio, seen.seq);
                end else begin
                    owed = owed_replies.pop_front();
                    if (m_tuser !== owed.status || seen.tag !== owed.job.tag ||
                        seen.prio !== owed.job.prio || seen.seq !== owed.job.seq) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result mismatch: expected status %0d job %h ",
                                      "prio %0d seq %0d, got status %0d job %h prio %0d seq %0d"},
                                     $realtime, owed.status, owed.job.tag, owed.job.prio,
                                     owed.job.seq, m_tuser, seen.tag, seen.prio, seen.seq);
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_replies.push_back(serve_request(s_tuser, entry_t'(s_tdata)));
        end
        outstanding = owed_replies.size();
    end

endmodule

/* bench/sorted_priority_queue_top_test.sv */
// Testbench top of the sorted priority queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
    import spq_pkg::*;

    localparam int DEPTH           = 8;
    // Cycles without any handshake before the run is declared hung; well above the
    // long receiver hold-off and the slowest insert.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_REQUESTS = 730;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [ENTRY_W-1:0] s_tdata  = '0;  // job_tag, priority_req, sequence_tag
    logic               s_tuser  = 1'b0;  // opcode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [ENTRY_W-1:0] m_tdata;  // out_job_tag, out_priority, out_sequence_tag
    logic [1:0]         m_tuser;  // status

    int  mismatches;
    int  outstanding;
    int  idle_cycles = 0;
    int  burst_left  = 0;
    // Ask the result side for its one long stall, and hear when it is over.
    bit  hold_off_req  = 1'b0;
    bit  hold_off_done = 1'b0;

    always #5 aclk = ~aclk;

    sorted_priority_queue_top #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sorted_priority_queue_check #(
        .QUEUE_DEPTH (DEPTH)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Build a job entry from its three fields.
    function automatic entry_t job(input logic [TAG_W-1:0] tag, input logic [PRIO_W-1:0] prio,
                                   input logic [SEQ_W-1:0] seq);
        entry_t e;
        e.tag  = tag;
        e.prio = prio;
        e.seq  = seq;
        return e;
    endfunction

    // Random filler for the data of a remove: the block ignores it.
    function automatic entry_t junk();
        return job($urandom, PRIO_W'($urandom_range(0, 255)), SEQ_W'($urandom_range(0, 255)));
    endfunction

    // Random key drawn so that equal priorities and equal keys come up often.
    function automatic entry_t random_job();
        logic [PRIO_W-1:0] prio;
        logic [SEQ_W-1:0]  seq;
        case ($urandom_range(0, 3))
            0: prio = PRIO_W'($urandom_range(0, 255));
            1: prio = PRIO_W'($urandom_range(0, 3));
            2: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: prio = PRIO_W'($urandom_range(100, 103));
        endcase
        seq = $urandom_range(0, 1) ? SEQ_W'($urandom_range(0, 255)) : SEQ_W'($urandom_range(0, 2));
        return job($urandom, prio, seq);
    endfunction

    // Offer one request and hold it until the block takes it. Start at a falling edge,
    // return at the falling edge after acceptance. Drop valid between bursts.
    task automatic send_request(input logic op, input entry_t req);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= req;
        // Read ready in the active region of the edge, before the block updates it.
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Result side: stall on a changing pattern, with one long hold-off on request.
    initial begin : result_sink
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                // Hold ready low while the sender keeps offering requests, so the block stalls with a result waiting.
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(negedge aclk);
                hold_off_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (phase % 3 != 0);
            endcase
        end
    end

    // Watchdog: count cycles in which neither channel moves a request or result.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int insert_pct;
        // Hold reset low from the start, release it at a falling edge.
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: remove on an empty queue.
        send_request(OP_REMOVE, junk());
        // Fill to capacity with extreme and tied keys.
        send_request(OP_INSERT, job(32'hFFFF_FFFF, 8'hFF, 8'hFF));
        send_request(OP_INSERT, job(32'h0000_0000, 8'h00, 8'h00));
        send_request(OP_INSERT, job(32'hA5A5_A5A5, 8'h80, 8'h10));
        send_request(OP_INSERT, job(32'h5A5A_5A5A, 8'h80, 8'h10));  // equal key, goes after
        send_request(OP_INSERT, job(32'h0000_0001, 8'h80, 8'h0F));
        send_request(OP_INSERT, job(32'h0000_0002, 8'h80, 8'h11));
        send_request(OP_INSERT, job(32'h0000_0003, 8'h7F, 8'hFF));
        send_request(OP_INSERT, job(32'h0000_0004, 8'h01, 8'h00));
        // Refuse an insert while full.
        send_request(OP_INSERT, job(32'hDEAD_0005, 8'h00, 8'h00));
        // Free one slot and reuse it at once, again with a tied key.
        send_request(OP_REMOVE, junk());
        send_request(OP_INSERT, job(32'h0000_0006, 8'h80, 8'h10));
        send_request(OP_INSERT, job(32'h0000_0007, 8'h00, 8'h00));
        // Drain everything, then one more remove on empty.
        repeat (DEPTH) send_request(OP_REMOVE, junk());
        send_request(OP_REMOVE, junk());

        // Random: segments with a changing insert share, so fill levels sweep from
        // empty to full and back.
        insert_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 50;
                    default: insert_pct = 25;
                endcase
            end
            // Start the long result stall once, while requests keep arriving.
            if (n == 150)
                hold_off_req = 1'b1;
            if ($urandom_range(0, 99) < insert_pct)
                send_request(OP_INSERT, random_job());
            else
                send_request(OP_REMOVE, junk());
        end
        s_tvalid <= 1'b0;

        // Wait until every owed result has arrived, then let stray results show up.
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_key_cmp.sv
hw/rtl/sorted_priority_queue_top.sv
hw/rtl/spq_checker.sv
bench/sorted_priority_queue_check.sv
bench/sorted_priority_queue_top_test.sv
